[hw/rtl/ttt_pkg.sv]
// shared constants and types of the timeout table timer
`default_nettype none

package ttt_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 32;
    localparam int TICK_W      = 10;
    localparam int SLOT_ID_W   = 4;
    localparam int OPCODE_W    = 2;

    localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

    localparam logic [OPCODE_W-1:0] OP_GET_TIME = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SET      = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CANCEL   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd3;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic              periodic;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] deadline;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_free;

endpackage

`default_nettype wire

[hw/rtl/ttt_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module ttt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/ttt_free_find.sv]
// lowest free slot finder over the slot valid bits
`default_nettype none

module ttt_free_find
    import ttt_pkg::*;
(
    input  wire logic [SLOTS-1:0] i_valid,
    output t_free                 o_free
);

    always_comb begin
        o_free.found = 1'b0;
        o_free.slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_valid[i]) begin
                o_free.found = 1'b1;
                o_free.slot  = SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/timeout_table_timer_unit.sv]
// top level of the timeout table timer: request handling, tick scan, result register
// get time, set and cancel reply in the cycle after acceptance, one word per cycle while o_in_stall is low
// a tick scans all slots, each in two steps (one ram read state, one evaluate and write back state)
// a tick holds off the next word through the scan and the flush state, plus any output stall
// reset: time 0, tick period 10 ms, all slots free, no result pending
`default_nettype none

module timeout_table_timer_unit
    import ttt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [TICK_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [OPCODE_W-1:0]  i_opcode,
    input  wire logic                 i_periodic_request,
    input  wire logic [TIME_W-1:0]    i_timeout_ms,
    input  wire logic [SLOT_ID_W-1:0] i_cancel_slot,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_result_kind,
    output logic                      o_status,
    output logic [SLOT_ID_W-1:0]      o_slot_id,
    output logic [TIME_W-1:0]         o_time_value,
    output logic                      o_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RD    = 2'd1;
    localparam logic [1:0] S_EV    = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [TIME_W-1:0]    r_time, n_time;
    logic [TICK_W-1:0]    r_period, n_period;
    logic [SLOTS-1:0]     r_valid, n_valid;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]    r_pend_slot, n_pend_slot;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic                 r_out_status, n_out_status;
    logic [SLOT_ID_W-1:0] r_out_slot, n_out_slot;
    logic [TIME_W-1:0]    r_out_time, n_out_time;
    logic                 r_out_last, n_out_last;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    t_entry               ram_wdata;
    t_entry               ram_rdata;
    t_free                free;

    logic                 out_free;
    logic                 due;
    logic                 hold;
    logic [SLOT_W-1:0]    cidx;
    logic                 cin_range;

    ttt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .ADDR_W(SLOT_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    ttt_free_find u_free (
        .i_valid(r_valid),
        .o_free (free)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign cidx       = SLOT_W'(i_cancel_slot);
    assign cin_range  = (32'(i_cancel_slot) < 32'(SLOTS));
    assign due        = r_valid[r_idx] && (ram_rdata.deadline <= r_time);
    assign hold       = due && r_pend_valid && !out_free;

    always_comb begin
        n_state      = r_state;
        n_time       = r_time;
        n_period     = r_period;
        n_valid      = r_valid;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = free.slot;
        ram_wdata.periodic = i_periodic_request;
        ram_wdata.period   = i_timeout_ms;
        ram_wdata.deadline = r_time + i_timeout_ms;

        if (i_cfg_we) begin
            n_period = i_cfg_data;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && out_free) begin
                    case (i_opcode)
                        OP_GET_TIME: begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_REPLY;
                            n_out_status = STATUS_OK;
                            n_out_slot   = '0;
                            n_out_time   = r_time;
                            n_out_last   = 1'b1;
                        end
                        OP_SET: begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_REPLY;
                            n_out_last  = 1'b1;
                            if (free.found) begin
                                n_valid[free.slot] = 1'b1;
                                ram_we       = 1'b1;
                                n_out_status = STATUS_OK;
                                n_out_slot   = SLOT_ID_W'(free.slot);
                                n_out_time   = r_time;
                            end else begin
                                n_out_status = STATUS_FAIL;
                                n_out_slot   = '0;
                                n_out_time   = '0;
                            end
                        end
                        OP_CANCEL: begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_REPLY;
                            n_out_slot  = '0;
                            n_out_time  = '0;
                            n_out_last  = 1'b1;
                            if (cin_range && r_valid[cidx]) begin
                                n_valid[cidx] = 1'b0;
                                n_out_status  = STATUS_OK;
                            end else begin
                                n_out_status  = STATUS_FAIL;
                            end
                        end
                        default: begin
                            n_time       = r_time + TIME_W'(r_period);
                            n_idx        = '0;
                            n_cnt        = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (!hold) begin
                    if (due) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = KIND_EXPIRY;
                            n_out_status = STATUS_OK;
                            n_out_slot   = SLOT_ID_W'(r_pend_slot);
                            n_out_time   = r_time;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_idx;
                        n_cnt        = r_cnt + 1'b1;
                        if (ram_rdata.periodic) begin
                            ram_we             = 1'b1;
                            ram_waddr          = r_idx;
                            ram_wdata.periodic = 1'b1;
                            ram_wdata.period   = ram_rdata.period;
                            ram_wdata.deadline = r_time + ram_rdata.period;
                        end else begin
                            n_valid[r_idx] = 1'b0;
                        end
                    end
                    if ((r_idx == SLOT_W'(SLOTS - 1)) ||
                        (due && (r_cnt == CNT_W'(MAX_RESULTS - 1)))) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_EXPIRY;
                    n_out_status = STATUS_OK;
                    n_out_slot   = SLOT_ID_W'(r_pend_slot);
                    n_out_time   = r_time;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_time       <= '0;
            r_period     <= TICK_RESET;
            r_valid      <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_period     <= n_period;
            r_valid      <= n_valid;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_slot  <= n_pend_slot;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_time   <= n_out_time;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_status      = r_out_status;
    assign o_slot_id     = r_out_slot;
    assign o_time_value  = r_out_time;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

[sim/tb_timeout_table_timer_unit.sv]
`timescale 1ns / 100ps
// self-checking testbench of the timeout table timer with its own timer table predictor

module tb_timeout_table_timer_unit;
    import ttt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

    typedef struct packed {
        logic [OPCODE_W-1:0]  op;
        logic                 periodic;
        logic [TIME_W-1:0]    timeout;
        logic [SLOT_ID_W-1:0] slot;
    } t_request;

    typedef struct packed {
        logic                 kind;
        logic                 status;
        logic [SLOT_ID_W-1:0] slot;
        logic [TIME_W-1:0]    tval;
        logic                 last;
    } t_notice;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [TICK_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OPCODE_W-1:0]  i_opcode = OP_GET_TIME;
    logic                 i_periodic_request = 1'b0;
    logic [TIME_W-1:0]    i_timeout_ms = '0;
    logic [SLOT_ID_W-1:0] i_cancel_slot = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_result_kind;
    logic                 o_status;
    logic [SLOT_ID_W-1:0] o_slot_id;
    logic [TIME_W-1:0]    o_time_value;
    logic                 o_last;

    timeout_table_timer_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_periodic_request (i_periodic_request),
        .i_timeout_ms       (i_timeout_ms),
        .i_cancel_slot      (i_cancel_slot),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_status           (o_status),
        .o_slot_id          (o_slot_id),
        .o_time_value       (o_time_value),
        .o_last             (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // timer table as the block should hold it
    logic [TICK_W-1:0] tick_ms = TICK_RESET;
    logic [TIME_W-1:0] now_ms = '0;
    logic              armed [SLOTS];
    logic              rearm [SLOTS];
    logic [TIME_W-1:0] period_ms [SLOTS];
    logic [TIME_W-1:0] due_at [SLOTS];

    t_request pending_requests [$];
    t_notice  expected_results [$];

    int  errors = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    bit  calm = 1'b0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            armed[i] = 1'b0;
            rearm[i] = 1'b0;
            period_ms[i] = '0;
            due_at[i] = '0;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        errors++;
    endtask

    task automatic predict_request(input t_request r);
        t_notice held;
        bit      have_held;
        bit      placed;
        int      fired;
        have_held = 1'b0;
        placed = 1'b0;
        fired = 0;
        case (r.op)
            OP_GET_TIME: begin
                expected_results.push_back({KIND_REPLY, STATUS_OK, 4'd0, now_ms, 1'b1});
            end
            OP_SET: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!placed && !armed[i]) begin
                        armed[i] = 1'b1;
                        rearm[i] = r.periodic;
                        period_ms[i] = r.timeout;
                        due_at[i] = now_ms + r.timeout;
                        expected_results.push_back({KIND_REPLY, STATUS_OK, SLOT_ID_W'(i),
                                                    now_ms, 1'b1});
                        placed = 1'b1;
                    end
                end
                if (!placed)
                    expected_results.push_back({KIND_REPLY, STATUS_FAIL, 4'd0, 32'd0, 1'b1});
            end
            OP_CANCEL: begin
                if (int'(r.slot) < SLOTS && armed[r.slot]) begin
                    armed[r.slot] = 1'b0;
                    rearm[r.slot] = 1'b0;
                    period_ms[r.slot] = '0;
                    expected_results.push_back({KIND_REPLY, STATUS_OK, 4'd0, 32'd0, 1'b1});
                end else begin
                    expected_results.push_back({KIND_REPLY, STATUS_FAIL, 4'd0, 32'd0, 1'b1});
                end
            end
            default: begin
                now_ms = now_ms + TIME_W'(tick_ms);
                for (int i = 0; i < SLOTS; i++) begin
                    if (fired < MAX_RESULTS && armed[i] && due_at[i] <= now_ms) begin
                        if (have_held)
                            expected_results.push_back(held);
                        held = {KIND_EXPIRY, STATUS_OK, SLOT_ID_W'(i), now_ms, 1'b0};
                        have_held = 1'b1;
                        fired++;
                        if (rearm[i]) begin
                            due_at[i] = now_ms + period_ms[i];
                        end else begin
                            armed[i] = 1'b0;
                            period_ms[i] = '0;
                        end
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    expected_results.push_back(held);
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_notice want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d slot %0d time %0d",
                                      o_result_kind, o_slot_id, o_time_value));
            return;
        end
        want = expected_results.pop_front();
        if (o_result_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", o_result_kind, want.kind));
        if (o_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
        if (o_slot_id !== want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", o_slot_id, want.slot));
        if (o_time_value !== want.tval)
            report_mismatch($sformatf("time %0d, want %0d", o_time_value, want.tval));
        if (o_last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", o_last, want.last));
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predict_request({i_opcode, i_periodic_request, i_timeout_ms, i_cancel_slot});
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    t_request nxt;
                    nxt = pending_requests.pop_front();
                    i_opcode <= nxt.op;
                    i_periodic_request <= nxt.periodic;
                    i_timeout_ms <= nxt.timeout;
                    i_cancel_slot <= nxt.slot;
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 17);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_result();
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 16);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_timeout_table_timer_unit NOT OK");
            $finish;
        end
    end

    task automatic queue_request(input logic [OPCODE_W-1:0] op, input logic periodic,
                                 input logic [TIME_W-1:0] timeout,
                                 input logic [SLOT_ID_W-1:0] slot);
        pending_requests.push_back({op, periodic, timeout, slot});
    endtask

    function automatic t_request random_request();
        t_request r;
        int       pick;
        int       spread;
        pick = $urandom_range(0, 99);
        spread = $urandom_range(0, 99);
        r.periodic = 1'($urandom_range(0, 1));
        r.slot = SLOT_ID_W'($urandom_range(0, 15));
        if (spread < 70)
            r.timeout = $urandom_range(0, 3000);
        else if (spread < 85)
            r.timeout = $urandom;
        else
            r.timeout = 32'hFFFF_FFFF - $urandom_range(0, 50);
        if (pick < 35)
            r.op = OP_SET;
        else if (pick < 70)
            r.op = OP_TICK;
        else if (pick < 85)
            r.op = OP_CANCEL;
        else
            r.op = OP_GET_TIME;
        return r;
    endfunction

    task automatic wait_quiet();
        while (pending_requests.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [TICK_W-1:0] period, input int count);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= period;
        tick_ms = period;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        for (int n = 0; n < count; n++)
            pending_requests.push_back(random_request());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_request(OP_GET_TIME, 1'b0, '0, '0);
        queue_request(OP_TICK, 1'b0, '0, '0);
        for (int i = 0; i < SLOTS; i++)
            queue_request(OP_SET, i[0], (i == 1) ? 32'hFFFF_FFFF : 32'(i * 5), '0);
        queue_request(OP_SET, 1'b1, 32'd7, '0);
        queue_request(OP_TICK, 1'b0, '0, '0);
        queue_request(OP_CANCEL, 1'b0, '0, 4'd3);
        queue_request(OP_CANCEL, 1'b0, '0, 4'd3);
        queue_request(OP_CANCEL, 1'b0, '0, 4'd0);
        queue_request(OP_TICK, 1'b0, '0, '0);
        queue_request(OP_GET_TIME, 1'b0, '0, '0);

        run_phase(10'd1000, 80);
        hold_req <= hold_req + 1;
        run_phase(10'd1, 80);
        run_phase(10'd0, 30);
        run_phase(10'd1023, 40);
        wait_quiet();
        calm <= 1'b1;
        run_phase(10'($urandom_range(1, 1000)), 120);
        wait_quiet();

        if (errors == 0)
            $display("tb_timeout_table_timer_unit OK");
        else
            $display("tb_timeout_table_timer_unit NOT OK");
        $finish;
    end

endmodule
